@@ src/hts_pkg.sv @@
// Shared types and entity tables for the HTML tag strip and entity decode block.
package hts_pkg;

   localparam int NUM_ENT     = 6;
   localparam int HOLD_DEPTH  = 5;
   localparam int BURST_DEPTH = HOLD_DEPTH + 1;
   localparam int TEXT_DEPTH  = HOLD_DEPTH + 1;

   localparam logic [7:0] CH_AMP  = 8'h26;
   localparam logic [7:0] CH_LT   = 8'h3C;
   localparam logic [7:0] CH_GT   = 8'h3E;
   localparam logic [7:0] CH_NONE = 8'h00;

   // register map (word index)
   localparam logic REG_OUTPUT_LIMIT = 1'b0;
   localparam logic [15:0] OUTPUT_LIMIT_RESET = 16'd4096;

   localparam logic [7:0] ENT_TEXT [NUM_ENT][TEXT_DEPTH] = '{
      '{"&", "a", "m", "p", ";", 8'h00},
      '{"&", "l", "t", ";", 8'h00, 8'h00},
      '{"&", "g", "t", ";", 8'h00, 8'h00},
      '{"&", "q", "u", "o", "t", ";"},
      '{"&", "a", "p", "o", "s", ";"},
      '{"&", "#", "3", "9", ";", 8'h00}
   };
   localparam logic [2:0] ENT_LEN [NUM_ENT] = '{3'd5, 3'd4, 3'd4, 3'd6, 3'd6, 3'd5};
   localparam logic [7:0] ENT_CHAR [NUM_ENT] = '{"&", "<", ">", 8'h22, 8'h27, 8'h27};

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       has_byte;
      logic       end_of_text;
   } rsp_type;

   // bytes caused by one item, already cut to the output limit
   typedef struct packed {
      logic [BURST_DEPTH-1:0][7:0] bytes;
      logic [2:0]                  count;
      logic                        last;
   } burst_type;

endpackage

@@ src/hts_parse.sv @@
// Parser: tag and entity state, builds the burst of bytes for each accepted item.
module hts_parse (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  hts_pkg::req_type   item,
   input  logic [15:0]        limit,
   output hts_pkg::burst_type burst
);
   import hts_pkg::*;

   logic                 inside_tag_ff, inside_tag_in;
   logic [2:0]           held_cnt_ff, held_cnt_in;
   logic [NUM_ENT-1:0]   mask_ff, mask_in;
   logic [15:0]          emitted_ff, emitted_in;
   logic [7:0]           held_ff [HOLD_DEPTH];
   logic [7:0]           held_in [HOLD_DEPTH];

   logic [NUM_ENT-1:0]   mask_next;
   logic                 complete;
   logic                 grows;
   logic [7:0]           ent_out;
   logic [2:0]           flush_cnt;
   logic                 x_valid;
   logic [7:0]           x_byte;
   logic [2:0]           total;
   logic [16:0]          used;
   logic [16:0]          room;
   logic [2:0]           allowed;
   logic [7:0]           b;

   assign b = item.in_byte;

   always_comb begin
      complete = 1'b0;
      grows    = 1'b0;
      ent_out  = CH_NONE;
      for (int e = NUM_ENT - 1; e >= 0; e--) begin
         mask_next[e] = mask_ff[e] && (ENT_LEN[e] > held_cnt_ff) &&
                        (ENT_TEXT[e][held_cnt_ff] == b);
         if (mask_next[e] && ENT_LEN[e] == held_cnt_ff + 3'd1) begin
            complete = 1'b1;
            ent_out  = ENT_CHAR[e];
         end
         if (mask_next[e] && ENT_LEN[e] > held_cnt_ff + 3'd1) begin
            grows = 1'b1;
         end
      end
   end

   always_comb begin
      inside_tag_in = inside_tag_ff;
      held_cnt_in   = held_cnt_ff;
      mask_in       = mask_ff;
      held_in       = held_ff;
      flush_cnt     = 3'd0;
      x_valid       = 1'b0;
      x_byte        = b;

      if (held_cnt_ff != 3'd0 && complete) begin
         held_cnt_in = 3'd0;
         x_valid     = 1'b1;
         x_byte      = ent_out;
      end else if (held_cnt_ff != 3'd0 && grows) begin
         for (int i = 0; i < HOLD_DEPTH; i++) begin
            if (3'(i) == held_cnt_ff) held_in[i] = b;
         end
         held_cnt_in = held_cnt_ff + 3'd1;
         mask_in     = mask_next;
         // a last item flushes the grown prefix: old held bytes then this one
         if (item.in_last) begin
            flush_cnt = held_cnt_ff;
            x_valid   = 1'b1;
         end
      end else begin
         // mismatch flushes the held bytes, then the byte is handled as plain
         flush_cnt   = held_cnt_ff;
         held_cnt_in = 3'd0;
         if (b == CH_LT) begin
            inside_tag_in = 1'b1;
         end else if (b == CH_GT) begin
            inside_tag_in = 1'b0;
         end else if (!inside_tag_ff) begin
            if (b == CH_AMP) begin
               held_in[0]  = CH_AMP;
               held_cnt_in = 3'd1;
               mask_in     = '1;
               x_valid     = item.in_last;
            end else begin
               x_valid = 1'b1;
            end
         end
      end
   end

   always_comb begin
      total = flush_cnt + {2'd0, x_valid};
      used  = {1'b0, emitted_ff} + 17'd1;
      room  = ({1'b0, limit} > used) ? ({1'b0, limit} - used) : 17'd0;
      allowed = (room >= {14'd0, total}) ? total : room[2:0];
      for (int i = 0; i < HOLD_DEPTH; i++) begin
         burst.bytes[i] = (3'(i) < flush_cnt) ? held_ff[i] : x_byte;
      end
      burst.bytes[BURST_DEPTH-1] = x_byte;
      burst.count = allowed;
      burst.last  = item.in_last;
      emitted_in  = item.in_last ? 16'd0 : emitted_ff + {13'd0, allowed};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inside_tag_ff <= 1'b0;
         held_cnt_ff   <= 3'd0;
         mask_ff       <= '0;
         emitted_ff    <= 16'd0;
      end else if (accept) begin
         inside_tag_ff <= item.in_last ? 1'b0 : inside_tag_in;
         held_cnt_ff   <= item.in_last ? 3'd0 : held_cnt_in;
         mask_ff       <= mask_in;
         emitted_ff    <= emitted_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         held_ff <= held_in;
      end
   end

endmodule

@@ src/hts_emit.sv @@
// Result register: holds one item's burst and sends it out a byte per cycle while rsp_ready is high.
module hts_emit (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  hts_pkg::burst_type burst,
   output logic               ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output hts_pkg::rsp_type   rsp_item
);
   import hts_pkg::*;

   logic [7:0] bytes_ff [BURST_DEPTH];
   logic [2:0] cnt_ff;
   logic       has_ff;
   logic       end_ff;
   logic       take;

   assign take      = rsp_valid && rsp_ready;
   assign rsp_valid = cnt_ff != 3'd0;
   assign ready     = (cnt_ff == 3'd0) || (cnt_ff == 3'd1 && rsp_ready);

   assign rsp_item.out_byte    = has_ff ? bytes_ff[0] : CH_NONE;
   assign rsp_item.has_byte    = has_ff;
   assign rsp_item.end_of_text = end_ff && cnt_ff == 3'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 3'd0;
      end else if (load) begin
         // a last item with nothing to send still yields a bare end marker
         cnt_ff <= (burst.count == 3'd0 && burst.last) ? 3'd1 : burst.count;
      end else if (take) begin
         cnt_ff <= cnt_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         for (int i = 0; i < BURST_DEPTH; i++) begin
            bytes_ff[i] <= burst.bytes[i];
         end
         has_ff <= burst.count != 3'd0;
         end_ff <= burst.last;
      end else if (take) begin
         for (int i = 0; i < BURST_DEPTH - 1; i++) begin
            bytes_ff[i] <= bytes_ff[i+1];
         end
      end
   end

endmodule

@@ src/html_tag_strip_entity_decode.sv @@
// Top level of the HTML tag strip and entity decode block.
//
//   channel  direction  handshake           payload
//   req      in         req_valid/ready     req_item: in_byte, in_last
//   rsp      out        rsp_valid/ready     rsp_item: out_byte, has_byte, end_of_text
//   csr      in/out     psel/penable/pready output_limit at byte address 0
//
// One item is taken per cycle while each item yields at most one result and rsp_ready is high.
// An item yielding k results (up to six on an entity mismatch flush) holds
// req_ready low until the result register drains to its last result.
// Reset is synchronous and clears parser state, the result register and
// sets output_limit to 4096. A stalled rsp holds the result register.
module html_tag_strip_entity_decode (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  hts_pkg::req_type req_item,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output hts_pkg::rsp_type rsp_item,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [2:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);
   import hts_pkg::*;

   logic [15:0] limit_ff;
   logic        accept;
   burst_type   burst;

   assign pready = 1'b1;
   assign accept = req_valid && req_ready;
   assign prdata = (paddr[2] == REG_OUTPUT_LIMIT) ? {16'd0, limit_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= OUTPUT_LIMIT_RESET;
      end else if (psel && penable && pwrite && pready && paddr[2] == REG_OUTPUT_LIMIT) begin
         limit_ff <= pwdata[15:0];
      end
   end

   hts_parse u_parse (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .item   (req_item),
      .limit  (limit_ff),
      .burst  (burst)
   );

   hts_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .burst     (burst),
      .ready     (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

endmodule
